### design/iphc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iphc_pkg;

    // Widest beat is eight bytes, so at most four 16-bit word lanes.
    localparam int unsigned MAX_LANES = 4;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_ADDR  = 2'd0,
        CFG_DST_ADDR  = 2'd1,
        CFG_PROTOCOL  = 2'd2,
        CFG_PSEUDO_EN = 2'd3
    } cfg_index_t;

    // One input item: a beat of packet bytes.
    typedef struct packed {
        logic [63:0] data_bytes;
        logic [3:0]  valid_bytes;
        logic        last;
    } in_t;

    // One result item.
    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] total_length;
    } out_t;

    // Control that travels with a beat between pipeline stages.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [15:0] len;
    } beat_ctrl_t;

    // Ones' complement add with end-around carry.
    function automatic word_t eac_add(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return word_t'(s[WORD_W-1:0] + word_t'(s[WORD_W]));
    endfunction

endpackage

`default_nettype wire

### design/iphc_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module iphc_lane import iphc_pkg::*; #(
    parameter int unsigned LANE_IDX = 0
) (
    input  wire logic        aclk,
    input  wire logic        adv,
    input  wire logic [15:0] pair_data,
    input  wire logic [3:0]  byte_count,
    output word_t            word_reg
);

    localparam logic [3:0] HI_POS = 4'(2 * LANE_IDX);
    localparam logic [3:0] LO_POS = 4'(2 * LANE_IDX + 1);

    word_t word_next;

    // Keep only the bytes that lie inside the valid count; a lone high byte is padded.
    always_comb begin
        word_next[15:8] = (HI_POS < byte_count) ? pair_data[15:8] : 8'h00;
        word_next[7:0]  = (LO_POS < byte_count) ? pair_data[7:0]  : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### design/iphc_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module iphc_merge import iphc_pkg::*; (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire word_t [MAX_LANES-1:0]       lane_words,
    input  wire beat_ctrl_t                  ctrl_in,
    input  wire logic                        down_ready,
    output logic                             up_ready,
    output word_t                            beat_sum_reg,
    output beat_ctrl_t                       ctrl_reg
);

    word_t pair_lo;
    word_t pair_hi;
    word_t beat_sum_next;

    // Two-level end-around-carry tree over the lane words.
    always_comb begin
        pair_lo       = eac_add(lane_words[0], lane_words[1]);
        pair_hi       = eac_add(lane_words[2], lane_words[3]);
        beat_sum_next = eac_add(pair_lo, pair_hi);
    end

    assign up_ready = !ctrl_reg.valid || down_ready;

    // Only the valid flag is reset; the payload follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (up_ready) begin
            ctrl_reg.valid <= ctrl_in.valid;
        end
        if (up_ready) begin
            ctrl_reg.last <= ctrl_in.last;
            ctrl_reg.len  <= ctrl_in.len;
            beat_sum_reg  <= beat_sum_next;
        end
    end

endmodule

`default_nettype wire

### design/iphc_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module iphc_accum import iphc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire word_t       beat_sum,
    input  wire beat_ctrl_t  beat_ctrl,
    input  wire word_t       cfg_sum,
    input  wire logic        pseudo_en,
    output logic             up_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data
);

    word_t running_reg;
    word_t running_next;
    word_t acc_beat;
    logic  take;

    logic  fin_valid_reg;
    word_t fin_acc_reg;
    logic [15:0] fin_len_reg;

    logic  cfg_valid_reg;
    word_t cfg_acc_reg;
    logic [15:0] cfg_len_reg;

    logic  out_valid_reg;
    out_t  out_reg;

    logic  ready_fin;
    logic  ready_cfg;
    logic  ready_out;

    // Backpressure runs from the output register back to the running sum.
    assign ready_out = !out_valid_reg || m_ready;
    assign ready_cfg = !cfg_valid_reg || ready_out;
    assign ready_fin = !fin_valid_reg || ready_cfg;
    assign up_ready  = ready_fin;

    // Fold the beat sum into the running sum; the last beat clears it.
    always_comb begin
        take         = beat_ctrl.valid && ready_fin;
        acc_beat     = eac_add(running_reg, beat_sum);
        running_next = running_reg;
        if (take) begin
            running_next = beat_ctrl.last ? '0 : acc_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
        end else begin
            running_reg <= running_next;
        end
    end

    // Valid flags of the finishing stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            cfg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ready_fin) begin
                fin_valid_reg <= take && beat_ctrl.last;
            end
            if (ready_cfg) begin
                cfg_valid_reg <= fin_valid_reg;
            end
            if (ready_out) begin
                out_valid_reg <= cfg_valid_reg;
            end
        end
    end

    // Packet sum, then address and protocol words and length if pseudo_en, then the complement.
    always_ff @(posedge aclk) begin
        if (ready_fin) begin
            fin_acc_reg <= acc_beat;
            fin_len_reg <= beat_ctrl.len;
        end
        if (ready_cfg) begin
            cfg_acc_reg <= eac_add(fin_acc_reg, pseudo_en ? cfg_sum : '0);
            cfg_len_reg <= fin_len_reg;
        end
        if (ready_out) begin
            out_reg.checksum     <= ~eac_add(cfg_acc_reg, pseudo_en ? cfg_len_reg : '0);
            out_reg.total_length <= cfg_len_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### design/ipv4_pseudo_header_checksum.sv
// Streaming RFC 1071 checksum with optional IPv4 pseudo header.
// Input items are packet beats on s_valid/s_ready/s_data: up to BYTES_PER_BEAT
// bytes, first byte in bits 63..56, a valid byte count and a last flag.
// One result item per packet appears on m_valid/m_ready/m_data after the last
// beat: the complemented folded sum and the byte count modulo 65536.
// Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write them only while no packet is in flight.
// Throughput is one beat per cycle while s_ready is high: each 16-bit word
// of a beat has its own lane, a merge tree sums the lanes, and one
// end-around-carry add per cycle keeps the running sum. The last beat passes
// every stage from the lanes to the output register. The output register is
// separate from the pipeline, so beats keep flowing while a result waits; a
// stalled m_ready fills the stages and then drops s_ready. Reset clears the
// registers, the running sum, the byte count and all pipeline valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_pseudo_header_checksum import iphc_pkg::*; #(
    parameter int unsigned BYTES_PER_BEAT = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned LANES = (BYTES_PER_BEAT + 1) / 2;
    localparam logic [3:0]  BEAT_MAX = 4'(BYTES_PER_BEAT);

    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [7:0]  protocol_reg;
    logic        pseudo_en_reg;
    word_t [1:0] cfg_part_reg;
    word_t       cfg_sum_reg;

    logic [15:0] byte_cnt_reg;
    logic [15:0] len_next;
    logic [3:0]  beat_count;
    logic        s_take;

    beat_ctrl_t            lane_ctrl_reg;
    word_t [MAX_LANES-1:0] lane_words;
    logic                  merge_ready;
    logic                  accum_ready;
    word_t                 beat_sum;
    beat_ctrl_t            beat_ctrl;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg  <= '0;
            dst_addr_reg  <= '0;
            protocol_reg  <= '0;
            pseudo_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SRC_ADDR:  src_addr_reg  <= cfg_data;
                CFG_DST_ADDR:  dst_addr_reg  <= cfg_data;
                CFG_PROTOCOL:  protocol_reg  <= cfg_data[7:0];
                CFG_PSEUDO_EN: pseudo_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pseudo header pre-sums; user changes them only while idle, not enforced.
    always_ff @(posedge aclk) begin
        cfg_part_reg[0] <= eac_add(src_addr_reg[31:16], src_addr_reg[15:0]);
        cfg_part_reg[1] <= eac_add(dst_addr_reg[31:16], dst_addr_reg[15:0]);
        cfg_sum_reg     <= eac_add(eac_add(cfg_part_reg[0], cfg_part_reg[1]),
                                   {8'h00, protocol_reg});
    end

    // Byte count of the beat, capped at the beat width, and the packet length.
    always_comb begin
        beat_count = (s_data.valid_bytes > BEAT_MAX) ? BEAT_MAX : s_data.valid_bytes;
        len_next   = 16'(byte_cnt_reg + 16'(beat_count));
        s_take     = s_valid && s_ready;
    end

    assign s_ready = !lane_ctrl_reg.valid || merge_ready;

    // Packet length counter and the control that travels with the lane words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg        <= '0;
            lane_ctrl_reg.valid <= 1'b0;
        end else begin
            if (s_take) begin
                byte_cnt_reg <= s_data.last ? '0 : len_next;
            end
            if (s_ready) begin
                lane_ctrl_reg.valid <= s_valid;
            end
        end
        if (s_ready) begin
            lane_ctrl_reg.last <= s_data.last;
            lane_ctrl_reg.len  <= len_next;
        end
    end

    // One lane per 16-bit word of the beat; unused lanes add zero.
    for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
        if (k < LANES) begin : g_used
            iphc_lane #(
                .LANE_IDX (k)
            ) u_lane (
                .aclk       (aclk),
                .adv        (s_ready),
                .pair_data  (s_data.data_bytes[63-16*k -: 16]),
                .byte_count (beat_count),
                .word_reg   (lane_words[k])
            );
        end else begin : g_unused
            assign lane_words[k] = '0;
        end
    end

    iphc_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lane_words   (lane_words),
        .ctrl_in      (lane_ctrl_reg),
        .down_ready   (accum_ready),
        .up_ready     (merge_ready),
        .beat_sum_reg (beat_sum),
        .ctrl_reg     (beat_ctrl)
    );

    iphc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_sum  (beat_sum),
        .beat_ctrl (beat_ctrl),
        .cfg_sum   (cfg_sum_reg),
        .pseudo_en (pseudo_en_reg),
        .up_ready  (accum_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
